### hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checking stays off while reset is held
`define ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/lldd_pkg.sv
package lldd_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int OP_W       = 2;
    localparam int TID_W      = 16;
    localparam int WEIGHT_W   = 32;
    localparam int RDEV_W     = 4;
    localparam int DEVF_W     = 4;
    localparam int STATUS_W   = 2;
    localparam int NDEV_W     = 5;
    localparam int TT_W       = 16;
    localparam int S_TDATA_W  = 56;
    localparam int M_TDATA_W  = 40;

    localparam int DIV_N_W    = TID_W + NDEV_W;
    localparam int DIV_D_W    = TT_W;
    localparam int DIV_CNT_W  = 5;
    localparam int PER_W      = NDEV_W;
    localparam int START_W    = DIV_N_W + PER_W;

    localparam int RESULT_LIMIT = 16;

    localparam logic [NDEV_W-1:0]   NUM_DEV_RESET     = 5'd1;
    localparam logic [NDEV_W-1:0]   NUM_Q_RESET       = 5'd1;
    localparam logic [TT_W-1:0]     TOTAL_TASKS_RESET = 16'd100;
    localparam logic [WEIGHT_W-1:0] CHUNK_LIMIT_RESET = 32'd100000;

    typedef enum logic [OP_W-1:0] {
        OP_WHOLE,
        OP_QUEUE,
        OP_SPLIT,
        OP_RELEASE
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK,
        STATUS_EMPTY,
        STATUS_OUTSIDE,
        STATUS_BAD_DEV
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_DEVICES,
        CFG_NUM_QUEUES,
        CFG_TOTAL_TASKS,
        CFG_CHUNK_LIMIT
    } cfg_reg_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_DIV_Q,
        S_DIV_P,
        S_QMUL,
        S_QCHK,
        S_SCAN,
        S_DRAIN,
        S_PLACE,
        S_ERR
    } state_t;

    typedef struct packed {
        logic    item_load;
        logic    scan_load;
        logic    scan_issue;
        logic    div_start_q;
        logic    div_start_per;
        logic    q_latch;
        logic    per_latch;
        logic    qmul;
        logic    place;
        logic    err_emit;
        status_t err_code;
    } dp_cmd_t;

    typedef struct packed {
        opcode_t op;
        logic    n_zero;
        logic    q_bad;
        logic    rel_bad;
        logic    div_done;
        logic    per_zero;
        logic    q_out;
        logic    scan_last;
        logic    out_free;
        logic    split_more;
    } dp_stat_t;

endpackage

### hdl/lldd_div.sv
module lldd_div import lldd_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [DIV_N_W-1:0] dividend,
    input  logic [DIV_D_W-1:0] divisor,
    output logic               done,
    output logic [DIV_N_W-1:0] quotient
);

    logic                 busy_reg, busy_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_N_W-1:0]   quo_reg, quo_next;
    logic [DIV_D_W-1:0]   rem_reg, rem_next;
    logic [DIV_D_W-1:0]   dvs_reg, dvs_next;

    logic [DIV_D_W:0]     shifted;
    logic [DIV_D_W+1:0]   diff;
    logic                 ge;

    always_comb begin
        shifted = {rem_reg, quo_reg[DIV_N_W-1]};
        diff    = {1'b0, shifted} - {2'b00, dvs_reg};
        ge      = !diff[DIV_D_W+1];
        done    = busy_reg && (cnt_reg == '0);

        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DIV_N_W);
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end else if (busy_reg && cnt_reg != '0) begin
            // one restoring step per cycle
            cnt_next = cnt_reg - DIV_CNT_W'(1);
            quo_next = {quo_reg[DIV_N_W-2:0], ge};
            rem_next = ge ? diff[DIV_D_W-1:0] : shifted[DIV_D_W-1:0];
        end else if (done) begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign quotient = quo_reg;

endmodule

### hdl/lldd_dp.sv
module lldd_dp import lldd_pkg::*; #(
    parameter int MAX_DEVICES = 16,
    parameter int LOAD_WIDTH  = 48
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  dp_cmd_t               cmd,
    output dp_stat_t              stat,
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [OP_W-1:0]       s_tuser,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,
    output logic                  m_tlast,
    output logic [STATUS_W-1:0]   m_tuser
);

    localparam int DEV_W = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;
    localparam int SUM_W = ((LOAD_WIDTH > WEIGHT_W) ? LOAD_WIDTH : WEIGHT_W) + 1;
    localparam int MXW   = NDEV_W + 2;
    localparam logic [SUM_W-1:0] LOAD_MAX    = (SUM_W'(1) << LOAD_WIDTH) - SUM_W'(1);
    localparam logic [MXW-1:0]   MAX_DEV_EXT = MXW'(MAX_DEVICES);

    // configuration
    logic [NDEV_W-1:0]   num_dev_reg;
    logic [NDEV_W-1:0]   num_q_reg;
    logic [TT_W-1:0]     total_reg;
    logic [WEIGHT_W-1:0] chunk_reg;

    // current transaction
    opcode_t             op_reg;
    logic [TID_W-1:0]    tid_reg;
    logic [WEIGHT_W-1:0] w_reg;
    logic [RDEV_W-1:0]   rdev_reg;
    logic [WEIGHT_W-1:0] rem_reg;
    logic [NDEV_W-1:0]   k_reg;

    // queue window
    logic [DIV_N_W-1:0]  q_reg;
    logic [PER_W-1:0]    per_reg;
    logic [START_W-1:0]  start_reg;

    // scan
    logic [DEV_W-1:0]    scan_idx_reg;
    logic [NDEV_W-1:0]   scan_cnt_reg;
    logic                scan_first_reg;
    logic                cmp_pending_reg;
    logic                cmp_first_reg;
    logic [DEV_W-1:0]    cmp_addr_reg;
    logic [DEV_W-1:0]    best_idx_reg;
    logic [LOAD_WIDTH-1:0] best_load_reg;

    // load memory
    logic [LOAD_WIDTH-1:0] load_mem [MAX_DEVICES];
    logic [MAX_DEVICES-1:0] vld_reg;
    logic [LOAD_WIDTH-1:0] rd_data_reg;
    logic                  rd_vld_reg;

    // result register
    logic                m_valid_reg;
    logic [DEVF_W-1:0]   out_dev_reg;
    logic [WEIGHT_W-1:0] out_sub_reg;
    logic                out_last_reg;
    status_t             out_status_reg;

    logic [NDEV_W-1:0]   n_dev;
    logic [NDEV_W-1:0]   lim;
    logic                div_start;
    logic [DIV_N_W-1:0]  div_dividend;
    logic [DIV_D_W-1:0]  div_divisor;
    logic                div_done;
    logic [DIV_N_W-1:0]  div_quo;
    logic [START_W:0]    win_end;
    logic [DEV_W-1:0]    win_start;
    logic [NDEV_W-1:0]   win_len;
    logic [LOAD_WIDTH-1:0] load_rd;
    logic [WEIGHT_W-1:0] chunk;
    logic [WEIGHT_W-1:0] rem_next;
    logic                split_more;
    logic [WEIGHT_W-1:0] pw;
    logic [SUM_W-1:0]    best_ext;
    logic [SUM_W-1:0]    w_ext;
    logic [SUM_W-1:0]    sum;
    logic [SUM_W-1:0]    add_load;
    logic [SUM_W-1:0]    take;
    logic [SUM_W-1:0]    rel_load;
    logic [LOAD_WIDTH-1:0] new_load;
    logic [WEIGHT_W-1:0] place_sub;

    always_comb begin
        n_dev = ({2'b00, num_dev_reg} > MAX_DEV_EXT) ? NDEV_W'(MAX_DEV_EXT) : num_dev_reg;
        lim   = (n_dev < NDEV_W'(RESULT_LIMIT)) ? n_dev : NDEV_W'(RESULT_LIMIT);

        div_start    = cmd.div_start_q || cmd.div_start_per;
        div_dividend = cmd.div_start_q ? ({NDEV_W'(0), tid_reg} * {TID_W'(0), num_q_reg})
                                       : DIV_N_W'(n_dev);
        div_divisor  = cmd.div_start_q ? total_reg : DIV_D_W'(num_q_reg);

        win_end = {1'b0, start_reg} + (START_W+1)'(per_reg);

        case (op_reg)
            OP_QUEUE: begin
                win_start = DEV_W'(start_reg);
                win_len   = per_reg;
            end
            OP_RELEASE: begin
                win_start = DEV_W'(rdev_reg);
                win_len   = NDEV_W'(1);
            end
            default: begin
                win_start = '0;
                win_len   = n_dev;
            end
        endcase

        load_rd = rd_vld_reg ? rd_data_reg : '0;

        chunk      = (rem_reg < chunk_reg) ? rem_reg : chunk_reg;
        rem_next   = (rem_reg > chunk_reg) ? (rem_reg - chunk_reg) : '0;
        split_more = (rem_next != '0) && ((k_reg + NDEV_W'(1)) < lim);

        pw       = (op_reg == OP_SPLIT) ? chunk : w_reg;
        best_ext = SUM_W'(best_load_reg);
        w_ext    = SUM_W'(w_reg);
        sum      = best_ext + SUM_W'(pw);
        add_load = (sum > LOAD_MAX) ? LOAD_MAX : sum;
        take     = (best_ext < w_ext) ? best_ext : w_ext;
        rel_load = best_ext - take;
        new_load = LOAD_WIDTH'((op_reg == OP_RELEASE) ? rel_load : add_load);
        place_sub = (op_reg == OP_RELEASE) ? WEIGHT_W'(take) : pw;

        stat.op         = op_reg;
        stat.n_zero     = (n_dev == '0);
        stat.q_bad      = (num_q_reg == '0) || (total_reg == '0);
        stat.rel_bad    = ({1'b0, rdev_reg} >= n_dev);
        stat.div_done   = div_done;
        stat.per_zero   = (per_reg == '0);
        stat.q_out      = (win_end > (START_W+1)'(n_dev));
        stat.scan_last  = (scan_cnt_reg == NDEV_W'(1));
        stat.out_free   = !m_valid_reg || m_tready;
        stat.split_more = split_more;
    end

    lldd_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_dev_reg <= NUM_DEV_RESET;
            num_q_reg   <= NUM_Q_RESET;
            total_reg   <= TOTAL_TASKS_RESET;
            chunk_reg   <= CHUNK_LIMIT_RESET;
        end else if (cfg_valid) begin
            case (cfg_reg_t'(cfg_index))
                CFG_NUM_DEVICES: num_dev_reg <= cfg_data[NDEV_W-1:0];
                CFG_NUM_QUEUES:  num_q_reg   <= cfg_data[NDEV_W-1:0];
                CFG_TOTAL_TASKS: total_reg   <= cfg_data[TT_W-1:0];
                CFG_CHUNK_LIMIT: chunk_reg   <= cfg_data[WEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.item_load) begin
            op_reg   <= opcode_t'(s_tuser);
            tid_reg  <= s_tdata[15:0];
            w_reg    <= s_tdata[47:16];
            rdev_reg <= s_tdata[51:48];
            rem_reg  <= s_tdata[47:16];
            k_reg    <= '0;
        end else if (cmd.place) begin
            rem_reg <= rem_next;
            k_reg   <= k_reg + NDEV_W'(1);
        end
        if (cmd.q_latch) begin
            q_reg <= div_quo;
        end
        if (cmd.per_latch) begin
            per_reg <= PER_W'(div_quo);
        end
        if (cmd.qmul) begin
            start_reg <= {PER_W'(0), q_reg} * {DIV_N_W'(0), per_reg};
        end
    end

    // scan issues one read per cycle, each compare runs in the cycle after its read
    always_ff @(posedge aclk) begin
        if (cmd.scan_load) begin
            scan_idx_reg   <= win_start;
            scan_cnt_reg   <= win_len;
            scan_first_reg <= 1'b1;
        end else if (cmd.scan_issue) begin
            scan_idx_reg   <= scan_idx_reg + DEV_W'(1);
            scan_cnt_reg   <= scan_cnt_reg - NDEV_W'(1);
            scan_first_reg <= 1'b0;
        end
        cmp_first_reg <= scan_first_reg;
        cmp_addr_reg  <= scan_idx_reg;
        if (cmp_pending_reg && (cmp_first_reg || load_rd < best_load_reg)) begin
            best_load_reg <= load_rd;
            best_idx_reg  <= cmp_addr_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmp_pending_reg <= 1'b0;
        end else begin
            cmp_pending_reg <= cmd.scan_issue;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= load_mem[scan_idx_reg];
        rd_vld_reg  <= vld_reg[scan_idx_reg];
        if (cmd.place) begin
            load_mem[best_idx_reg] <= new_load;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (cmd.place) begin
            vld_reg[best_idx_reg] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.place || cmd.err_emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.place) begin
            out_dev_reg    <= DEVF_W'(best_idx_reg);
            out_sub_reg    <= place_sub;
            out_last_reg   <= (op_reg == OP_SPLIT) ? !split_more : 1'b1;
            out_status_reg <= STATUS_OK;
        end else if (cmd.err_emit) begin
            out_dev_reg    <= (cmd.err_code == STATUS_BAD_DEV) ? rdev_reg : '0;
            out_sub_reg    <= '0;
            out_last_reg   <= 1'b1;
            out_status_reg <= cmd.err_code;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(M_TDATA_W-WEIGHT_W-DEVF_W)'(0), out_sub_reg, out_dev_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_status_reg;

endmodule

### hdl/lldd_ctrl.sv
module lldd_ctrl import lldd_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    output dp_cmd_t  cmd,
    input  dp_stat_t stat
);

    state_t  state_reg, state_next;
    status_t err_reg, err_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            err_reg   <= STATUS_OK;
        end else begin
            state_reg <= state_next;
            err_reg   <= err_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        err_next   = err_reg;
        cmd        = '0;
        cmd.err_code = err_reg;
        s_tready   = 1'b0;

        case (state_reg)
            S_IDLE: begin
                s_tready      = 1'b1;
                cmd.item_load = s_tvalid;
                if (s_tvalid) begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                case (stat.op)
                    OP_QUEUE: begin
                        if (stat.q_bad || stat.n_zero) begin
                            err_next   = STATUS_EMPTY;
                            state_next = S_ERR;
                        end else begin
                            cmd.div_start_q = 1'b1;
                            state_next      = S_DIV_Q;
                        end
                    end
                    OP_RELEASE: begin
                        if (stat.rel_bad) begin
                            err_next   = STATUS_BAD_DEV;
                            state_next = S_ERR;
                        end else begin
                            cmd.scan_load = 1'b1;
                            state_next    = S_SCAN;
                        end
                    end
                    default: begin
                        if (stat.n_zero) begin
                            err_next   = STATUS_EMPTY;
                            state_next = S_ERR;
                        end else begin
                            cmd.scan_load = 1'b1;
                            state_next    = S_SCAN;
                        end
                    end
                endcase
            end
            S_DIV_Q: begin
                if (stat.div_done) begin
                    cmd.q_latch       = 1'b1;
                    cmd.div_start_per = 1'b1;
                    state_next        = S_DIV_P;
                end
            end
            S_DIV_P: begin
                if (stat.div_done) begin
                    cmd.per_latch = 1'b1;
                    state_next    = S_QMUL;
                end
            end
            S_QMUL: begin
                cmd.qmul = 1'b1;
                if (stat.per_zero) begin
                    err_next   = STATUS_EMPTY;
                    state_next = S_ERR;
                end else begin
                    state_next = S_QCHK;
                end
            end
            S_QCHK: begin
                if (stat.q_out) begin
                    err_next   = STATUS_OUTSIDE;
                    state_next = S_ERR;
                end else begin
                    cmd.scan_load = 1'b1;
                    state_next    = S_SCAN;
                end
            end
            S_SCAN: begin
                cmd.scan_issue = 1'b1;
                if (stat.scan_last) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                state_next = S_PLACE;
            end
            S_PLACE: begin
                if (stat.out_free) begin
                    cmd.place = 1'b1;
                    if (stat.op == OP_SPLIT && stat.split_more) begin
                        cmd.scan_load = 1'b1;
                        state_next    = S_SCAN;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_ERR: begin
                if (stat.out_free) begin
                    cmd.err_emit = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

### hdl/least_loaded_device_dispatcher_top.sv
// Least-loaded device dispatcher.
// Input channel s_*: one transaction per task command. s_tuser carries the
// opcode (assign whole, assign by queue, assign split, release).
// Result channel m_*: one transaction per placement or error; split commands
// give up to min(device count, 16) results, the final one with m_tlast high.
// Configuration channel cfg_*: always ready. The user must see that it is
// written only between commands; the block itself does not enforce this.
// A placement scans its device window one load counter per cycle. Queue mode
// first makes two passes of the shared radix-2 divider (queue index, then
// devices per queue) and goes through the window multiply and range check
// states. Each further split chunk rescans the whole device window.
// One command is in flight at a time; the next is accepted the cycle after
// the last result is loaded into the output register, even if that result
// is still waiting.
// Reset clears all load counters (per-device valid bits) and restores the
// configuration defaults. If the receiver stalls, the held result stays
// unchanged and the block waits before loading the next one.
module least_loaded_device_dispatcher_top import lldd_pkg::*; #(
    parameter int MAX_DEVICES = 16,
    parameter int LOAD_WIDTH  = 48
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // task_id, weight, release_device
    input  logic [OP_W-1:0]       s_tuser,   // opcode
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // device, sub_weight
    output logic                  m_tlast,
    output logic [STATUS_W-1:0]   m_tuser,   // status
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    assign cfg_ready = 1'b1;

    lldd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    lldd_dp #(
        .MAX_DEVICES (MAX_DEVICES),
        .LOAD_WIDTH  (LOAD_WIDTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule

### hdl/lldd_checker.sv
`include "assert_macros.svh"

module lldd_checker import lldd_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tlast,
    input logic [STATUS_W-1:0]  m_tuser
);

    `ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser), "stalled result changed")

    `ASSERT_NEXT(a_one_cmd, aclk, aresetn, s_tvalid && s_tready, !s_tready, "second command accepted while busy")

    `ASSERT_IMPL(a_err_last, aclk, aresetn, m_tvalid && m_tuser != STATUS_OK, m_tlast, "error result not final")

    `ASSERT_IMPL(a_err_zero, aclk, aresetn, m_tvalid && m_tuser != STATUS_OK, m_tdata[35:4] == '0, "error result carries weight")

endmodule

bind least_loaded_device_dispatcher_top lldd_checker u_lldd_checker (.*);

### tb/least_loaded_device_dispatcher_top_test.sv
module least_loaded_device_dispatcher_top_test;
    import lldd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_DEV = 16;
    localparam int LOAD_W = 48;
    localparam logic [LOAD_W-1:0] LOAD_MAX = {LOAD_W{1'b1}};
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int DRAIN_CYCLES = 200;

    typedef struct packed {
        logic [DEVF_W-1:0]   device;
        logic [WEIGHT_W-1:0] sub_weight;
        logic                last;
        status_t             status;
    } placement_t;

    logic                  aclk;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic [OP_W-1:0]       s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tlast;
    logic [STATUS_W-1:0]   m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // predictor copy of configuration and load counters
    logic [NDEV_W-1:0]   cfg_num_devices = NUM_DEV_RESET;
    logic [NDEV_W-1:0]   cfg_num_queues = NUM_Q_RESET;
    logic [TT_W-1:0]     cfg_total_tasks = TOTAL_TASKS_RESET;
    logic [WEIGHT_W-1:0] cfg_chunk_limit = CHUNK_LIMIT_RESET;
    logic [LOAD_W-1:0]   dev_load [MAX_DEV];

    placement_t expected_placements [$];
    int mismatch_count = 0;
    int cycle_count = 0;
    int src_idle_pct = 0;
    int snk_stall_pct = 0;

    least_loaded_device_dispatcher_top #(
        .MAX_DEVICES(MAX_DEV),
        .LOAD_WIDTH (LOAD_W)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("status: fail");
            $finish;
        end
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= snk_stall_pct);
    end

    task automatic report_mismatch(string msg);
        mismatch_count++;
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
    endtask

    // result checker
    always @(posedge aclk) begin
        placement_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_placements.size() == 0) begin
                report_mismatch($sformatf("result with nothing expected, device %0d",
                                          m_tdata[3:0]));
            end else begin
                want = expected_placements.pop_front();
                if (m_tdata[3:0] !== want.device)
                    report_mismatch($sformatf("device got %0d want %0d",
                                              m_tdata[3:0], want.device));
                if (m_tdata[35:4] !== want.sub_weight)
                    report_mismatch($sformatf("sub_weight got %0d want %0d",
                                              m_tdata[35:4], want.sub_weight));
                if (m_tlast !== want.last)
                    report_mismatch($sformatf("last got %0b want %0b", m_tlast, want.last));
                if (m_tuser !== want.status)
                    report_mismatch($sformatf("status got %0d want %0d",
                                              m_tuser, want.status));
            end
        end
    end

    function automatic int device_count();
        return (cfg_num_devices > MAX_DEV) ? MAX_DEV : int'(cfg_num_devices);
    endfunction

    // least-loaded search over a window, lowest index wins a tie
    function automatic int place_least_loaded(int start, int len, logic [WEIGHT_W-1:0] w);
        int best;
        logic [LOAD_W:0] sum;
        best = start;
        for (int i = start + 1; i < start + len; i++) begin
            if (dev_load[i] < dev_load[best])
                best = i;
        end
        sum = {1'b0, dev_load[best]} + w;
        dev_load[best] = (sum > {1'b0, LOAD_MAX}) ? LOAD_MAX : sum[LOAD_W-1:0];
        return best;
    endfunction

    task automatic push_placement(int dev, logic [WEIGHT_W-1:0] w, logic last, status_t st);
        placement_t p;
        p.device = DEVF_W'(dev);
        p.sub_weight = w;
        p.last = last;
        p.status = st;
        expected_placements.push_back(p);
    endtask

    task automatic predict_dispatch(opcode_t op, logic [TID_W-1:0] tid,
                                    logic [WEIGHT_W-1:0] w, logic [RDEV_W-1:0] rdev);
        int n;
        int k;
        longint unsigned q;
        longint unsigned per;
        longint unsigned start;
        longint unsigned rem;
        longint unsigned chunk;
        longint unsigned lim;
        logic [LOAD_W-1:0] take;
        n = device_count();
        case (op)
            OP_WHOLE: begin
                if (n == 0)
                    push_placement(0, '0, 1'b1, STATUS_EMPTY);
                else
                    push_placement(place_least_loaded(0, n, w), w, 1'b1, STATUS_OK);
            end
            OP_QUEUE: begin
                if (cfg_num_queues == 0 || cfg_total_tasks == 0 || n == 0) begin
                    push_placement(0, '0, 1'b1, STATUS_EMPTY);
                end else begin
                    q = (64'(tid) * 64'(cfg_num_queues)) / 64'(cfg_total_tasks);
                    per = 64'(n) / 64'(cfg_num_queues);
                    start = q * per;
                    if (per == 0)
                        push_placement(0, '0, 1'b1, STATUS_EMPTY);
                    else if (start + per > 64'(n))
                        push_placement(0, '0, 1'b1, STATUS_OUTSIDE);
                    else
                        push_placement(place_least_loaded(int'(start), int'(per), w),
                                       w, 1'b1, STATUS_OK);
                end
            end
            OP_SPLIT: begin
                if (n == 0) begin
                    push_placement(0, '0, 1'b1, STATUS_EMPTY);
                end else begin
                    rem = w;
                    lim = cfg_chunk_limit;
                    k = 0;
                    do begin
                        chunk = (rem < lim) ? rem : lim;
                        rem = (rem > lim) ? rem - lim : 0;
                        k++;
                        push_placement(place_least_loaded(0, n, WEIGHT_W'(chunk)),
                                       WEIGHT_W'(chunk), !(rem > 0 && k < n), STATUS_OK);
                    end while (rem > 0 && k < n);
                end
            end
            default: begin
                if (int'(rdev) >= n) begin
                    push_placement(rdev, '0, 1'b1, STATUS_BAD_DEV);
                end else begin
                    take = (dev_load[rdev] < w) ? dev_load[rdev] : LOAD_W'(w);
                    dev_load[rdev] = dev_load[rdev] - take;
                    push_placement(rdev, WEIGHT_W'(take), 1'b1, STATUS_OK);
                end
            end
        endcase
    endtask

    task automatic send_item(opcode_t op, logic [TID_W-1:0] tid,
                             logic [WEIGHT_W-1:0] w, logic [RDEV_W-1:0] rdev);
        @(negedge aclk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {{(S_TDATA_W - TID_W - WEIGHT_W - RDEV_W){1'b0}}, rdev, w, tid};
        do @(posedge aclk); while (!s_tready);
        predict_dispatch(op, tid, w, rdev);
    endtask

    task automatic write_register(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_NUM_DEVICES: cfg_num_devices = val[NDEV_W-1:0];
            CFG_NUM_QUEUES:  cfg_num_queues = val[NDEV_W-1:0];
            CFG_TOTAL_TASKS: cfg_total_tasks = val[TT_W-1:0];
            default:         cfg_chunk_limit = val[WEIGHT_W-1:0];
        endcase
    endtask

    // registers change only once every outstanding result is back
    task automatic set_config(logic [NDEV_W-1:0] nd, logic [NDEV_W-1:0] nq,
                              logic [TT_W-1:0] tt, logic [WEIGHT_W-1:0] cl);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_placements.size() != 0) @(negedge aclk);
        write_register(CFG_NUM_DEVICES, CFG_DATA_W'(nd));
        write_register(CFG_NUM_QUEUES, CFG_DATA_W'(nq));
        write_register(CFG_TOTAL_TASKS, CFG_DATA_W'(tt));
        write_register(CFG_CHUNK_LIMIT, CFG_DATA_W'(cl));
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_reset_config();
        send_item(OP_WHOLE, 16'd0, 32'd5, 4'd0);
        send_item(OP_RELEASE, 16'd0, 32'd9, 4'd0);
        send_item(OP_RELEASE, 16'd0, 32'd1, 4'd1);
        send_item(OP_QUEUE, 16'd0, 32'd3, 4'd0);
        send_item(OP_QUEUE, 16'd100, 32'd3, 4'd0);
        send_item(OP_SPLIT, 16'd0, 32'd250000, 4'd0);
    endtask

    task automatic test_least_loaded_ties();
        set_config(5'd4, 5'd2, 16'd8, 32'hFFFF_FFFF);
        send_item(OP_WHOLE, 16'd0, 32'd0, 4'd0);
        send_item(OP_WHOLE, 16'd0, 32'hFFFF_FFFF, 4'd0);
        send_item(OP_WHOLE, 16'd0, 32'd1, 4'd0);
        send_item(OP_WHOLE, 16'd0, 32'd1, 4'd0);
        send_item(OP_QUEUE, 16'd7, 32'd2, 4'd0);
        send_item(OP_QUEUE, 16'd0, 32'd2, 4'd0);
        send_item(OP_QUEUE, 16'hFFFF, 32'd2, 4'd0);
    endtask

    task automatic test_empty_windows();
        set_config(5'd0, 5'd1, 16'd100, 32'd100);
        send_item(OP_WHOLE, 16'd0, 32'd10, 4'd0);
        send_item(OP_QUEUE, 16'd0, 32'd10, 4'd0);
        send_item(OP_SPLIT, 16'd0, 32'd10, 4'd0);
        send_item(OP_RELEASE, 16'd0, 32'd10, 4'hF);
        set_config(5'd2, 5'd4, 16'd100, 32'd100);
        send_item(OP_QUEUE, 16'd1, 32'd10, 4'd0);
        set_config(5'd16, 5'd0, 16'd100, 32'd100);
        send_item(OP_QUEUE, 16'd1, 32'd10, 4'd0);
        set_config(5'd16, 5'd1, 16'd0, 32'd100);
        send_item(OP_QUEUE, 16'd1, 32'd10, 4'd0);
    endtask

    task automatic test_split_chunks();
        set_config(5'd31, 5'd1, 16'd100, 32'd0);
        send_item(OP_SPLIT, 16'd0, 32'd7, 4'd0);
        set_config(5'd5, 5'd1, 16'd100, 32'd1000);
        send_item(OP_SPLIT, 16'd0, 32'd0, 4'd0);
        send_item(OP_SPLIT, 16'd0, 32'd2500, 4'd0);
        send_item(OP_SPLIT, 16'd0, 32'd10000, 4'd0);
        set_config(5'd16, 5'd1, 16'd100, 32'hFFFF_FFFF);
        send_item(OP_SPLIT, 16'd0, 32'hFFFF_FFFF, 4'd0);
    endtask

    task automatic test_release_clamp();
        send_item(OP_RELEASE, 16'hFFFF, 32'hFFFF_FFFF, 4'd15);
        send_item(OP_RELEASE, 16'd0, 32'hFFFF_FFFF, 4'd0);
    endtask

    task automatic random_config();
        logic [NDEV_W-1:0] nd;
        logic [NDEV_W-1:0] nq;
        logic [TT_W-1:0] tt;
        logic [WEIGHT_W-1:0] cl;
        int n;
        case ($urandom_range(9))
            0: nd = 5'd0;
            1: nd = 5'd31;
            2: nd = 5'd16;
            3: nd = 5'd1;
            default: nd = NDEV_W'($urandom_range(16, 2));
        endcase
        n = (nd > MAX_DEV) ? MAX_DEV : int'(nd);
        case ($urandom_range(9))
            0: nq = 5'd0;
            1: nq = 5'd31;
            2: nq = 5'd1;
            default: nq = NDEV_W'($urandom_range((n > 0) ? n : 1, 1));
        endcase
        case ($urandom_range(9))
            0: tt = 16'd0;
            1: tt = 16'd1;
            2: tt = 16'hFFFF;
            3: tt = TT_W'($urandom);
            default: tt = TT_W'($urandom_range(200, 1));
        endcase
        case ($urandom_range(9))
            0: cl = 32'd0;
            1: cl = 32'd1;
            2: cl = 32'hFFFF_FFFF;
            3: cl = $urandom;
            default: cl = $urandom_range(5000, 1);
        endcase
        set_config(nd, nq, tt, cl);
    endtask

    task automatic send_random_item();
        opcode_t op;
        logic [TID_W-1:0] tid;
        logic [WEIGHT_W-1:0] w;
        logic [RDEV_W-1:0] rdev;
        int n;
        n = device_count();
        op = opcode_t'($urandom_range(3));
        if ($urandom_range(9) < 8 && cfg_total_tasks != 0)
            tid = TID_W'($urandom_range(int'(cfg_total_tasks) - 1));
        else
            tid = TID_W'($urandom);
        case ($urandom_range(9))
            0: w = 32'd0;
            1: w = 32'hFFFF_FFFF;
            2: w = $urandom;
            default: w = $urandom_range(20000);
        endcase
        if ($urandom_range(9) < 8 && n > 0)
            rdev = RDEV_W'($urandom_range(n - 1));
        else
            rdev = RDEV_W'($urandom_range(15));
        send_item(op, tid, w, rdev);
    endtask

    task automatic test_random_traffic(int src_idle, int snk_stall, int items);
        src_idle_pct = src_idle;
        snk_stall_pct = snk_stall;
        random_config();
        for (int i = 0; i < items; i++) begin
            if (i > 0 && i % 35 == 0)
                random_config();
            send_random_item();
        end
    endtask

    initial begin
        for (int i = 0; i < MAX_DEV; i++)
            dev_load[i] = '0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_config();
        test_least_loaded_ties();
        test_empty_windows();
        test_split_chunks();
        test_release_clamp();

        test_random_traffic(0, 0, 105);
        test_random_traffic(74, 0, 105);
        test_random_traffic(0, 74, 105);
        test_random_traffic(29, 29, 105);

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_placements.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

### least_loaded_device_dispatcher_top.f
+incdir+hdl
hdl/lldd_pkg.sv
hdl/lldd_div.sv
hdl/lldd_dp.sv
hdl/lldd_ctrl.sv
hdl/least_loaded_device_dispatcher_top.sv
hdl/lldd_checker.sv
tb/least_loaded_device_dispatcher_top_test.sv
